// ===== src/lesf_pkg.sv =====
// Shared types and constants for the largest empty square finder.
`timescale 1ns / 1ps

package lesf_pkg;

    // Fixed field widths
    localparam int CHAR_W     = 8;
    localparam int GW_W       = 11;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_CHAR  = 2'd0,
        CFG_GRID_WIDTH  = 2'd1,
        CFG_GRID_HEIGHT = 2'd2
    } cfg_idx_t;

    // Configuration reset values
    localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST  = 8'd46;
    localparam logic [GW_W-1:0]   GRID_WIDTH_RST  = 11'd1;
    localparam logic [ROW_W-1:0]  GRID_HEIGHT_RST = 16'd1;

    // Position flags of a cell in the scan
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
        logic last_cell;
    } cell_pos_t;

endpackage

// ===== src/lesf_line_buf.sv =====
// Line buffer of square sizes for the row above, registered read with write-through.
`timescale 1ns / 1ps

module lesf_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 11
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a same-cycle write to the same entry is passed through
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/lesf_cell_seq.sv =====
// Input stage: scan position counters, line buffer read issue and cell register.
`timescale 1ns / 1ps

module lesf_cell_seq #(
    parameter int COL_W = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [COL_W-1:0]              col_last,
    input  logic [lesf_pkg::ROW_W-1:0]    row_last,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lesf_pkg::CHAR_W-1:0]   cell_byte,
    input  logic                          s1_fire,
    output logic                          s1_valid,
    output logic [lesf_pkg::CHAR_W-1:0]   s1_cell,
    output logic [COL_W-1:0]              s1_col,
    output logic [lesf_pkg::ROW_W-1:0]    s1_row,
    output lesf_pkg::cell_pos_t           s1_pos,
    output logic                          rd_en,
    output logic [COL_W-1:0]              rd_addr
);

    import lesf_pkg::*;

    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [CHAR_W-1:0] s1_cell_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    cell_pos_t        s1_pos_reg;
    cell_pos_t        pos_now;
    logic             accept;

    // Handshake: a new request enters when stage 1 is empty or draining
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;
    assign rd_en    = accept;
    assign rd_addr  = col_count_reg;

    // Position flags of the incoming cell
    always_comb
    begin
        pos_now.first_row = (row_count_reg == '0);
        pos_now.first_col = (col_count_reg == '0);
        pos_now.last_col  = (col_count_reg == col_last);
        pos_now.last_cell = (col_count_reg == col_last) && (row_count_reg == row_last);
    end

    // Scan counters
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (restart)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (accept)
        begin
            if (pos_now.last_col)
            begin
                col_count_next = '0;
                row_count_next = pos_now.last_cell ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    // Stage 1 occupancy
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    // Cell payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg <= cell_byte;
            s1_col_reg  <= col_count_reg;
            s1_row_reg  <= row_count_reg;
            s1_pos_reg  <= pos_now;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_cell  = s1_cell_reg;
    assign s1_col   = s1_col_reg;
    assign s1_row   = s1_row_reg;
    assign s1_pos   = s1_pos_reg;

endmodule

// ===== src/lesf_square_track.sv =====
// Stage 1: square size of a cell from its neighbors, and tracking of the best square.
`timescale 1ns / 1ps

module lesf_square_track #(
    parameter int COL_W  = 10,
    parameter int SIZE_W = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [lesf_pkg::CHAR_W-1:0]   empty_char,
    input  logic                          s1_valid,
    input  logic [lesf_pkg::CHAR_W-1:0]   s1_cell,
    input  logic [COL_W-1:0]              s1_col,
    input  logic [lesf_pkg::ROW_W-1:0]    s1_row,
    input  lesf_pkg::cell_pos_t           s1_pos,
    input  logic [SIZE_W-1:0]             up_mem,
    input  logic                          out_busy,
    output logic                          s1_fire,
    output logic                          wr_en,
    output logic [COL_W-1:0]              wr_addr,
    output logic [SIZE_W-1:0]             wr_data,
    output logic                          res_load,
    output logic [lesf_pkg::ROW_W-1:0]    res_row,
    output logic [COL_W-1:0]              res_col,
    output logic [SIZE_W-1:0]             res_size
);

    import lesf_pkg::*;

    logic [SIZE_W-1:0] left_reg;
    logic [SIZE_W-1:0] left_next;
    logic [SIZE_W-1:0] diag_reg;
    logic [SIZE_W-1:0] diag_next;
    logic [SIZE_W-1:0] top_size_reg;
    logic [SIZE_W-1:0] top_size_next;
    logic [ROW_W-1:0]  top_row_reg;
    logic [ROW_W-1:0]  top_row_next;
    logic [COL_W-1:0]  top_col_reg;
    logic [COL_W-1:0]  top_col_next;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] diag;
    logic [SIZE_W-1:0] min_ul;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] size;
    logic              better;
    logic [SIZE_W-1:0] best_size;
    logic [ROW_W-1:0]  best_row;
    logic [COL_W-1:0]  best_col;

    // Hold the last cell while the result register is still occupied
    assign s1_fire = s1_valid && !(s1_pos.last_cell && out_busy);

    // Neighbor sizes, zero outside the grid
    always_comb
    begin
        up   = s1_pos.first_row ? '0 : up_mem;
        left = s1_pos.first_col ? '0 : left_reg;
        diag = (s1_pos.first_row || s1_pos.first_col) ? '0 : diag_reg;
        min_ul  = (up < left) ? up : left;
        min_all = (min_ul < diag) ? min_ul : diag;
        size    = (s1_cell == empty_char) ? min_all + SIZE_W'(1) : '0;
    end

    // Best square so far including this cell; ties keep the earlier one
    always_comb
    begin
        better = (size > top_size_reg);
        if (better)
        begin
            best_size = size;
            best_row  = s1_row + ROW_W'(1) - ROW_W'(size);
            best_col  = s1_col + COL_W'(1) - COL_W'(size);
        end
        else
        begin
            best_size = top_size_reg;
            best_row  = top_row_reg;
            best_col  = top_col_reg;
        end
    end

    // State update
    always_comb
    begin
        left_next     = left_reg;
        diag_next     = diag_reg;
        top_size_next = top_size_reg;
        top_row_next  = top_row_reg;
        top_col_next  = top_col_reg;
        if (restart)
        begin
            left_next     = '0;
            diag_next     = '0;
            top_size_next = '0;
            top_row_next  = '0;
            top_col_next  = '0;
        end
        else if (s1_fire)
        begin
            left_next = s1_pos.last_col ? '0 : size;
            diag_next = s1_pos.last_col ? '0 : up;
            if (s1_pos.last_cell)
            begin
                top_size_next = '0;
                top_row_next  = '0;
                top_col_next  = '0;
            end
            else
            begin
                top_size_next = best_size;
                top_row_next  = best_row;
                top_col_next  = best_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            diag_reg     <= '0;
            top_size_reg <= '0;
            top_row_reg  <= '0;
            top_col_reg  <= '0;
        end
        else
        begin
            left_reg     <= left_next;
            diag_reg     <= diag_next;
            top_size_reg <= top_size_next;
            top_row_reg  <= top_row_next;
            top_col_reg  <= top_col_next;
        end
    end

    // Line buffer write and result hand-off
    assign wr_en    = s1_fire;
    assign wr_addr  = s1_col;
    assign wr_data  = size;
    assign res_load = s1_fire && s1_pos.last_cell;
    assign res_row  = best_row;
    assign res_col  = best_col;
    assign res_size = best_size;

endmodule

// ===== src/largest_empty_square_finder_core.sv =====
// Largest empty square finder: top level with configuration, result register and checks.
// The request carrying the last cell passes stage 1 and then loads the result register.
// Throughput: one cell request per cycle unless the last cell is held; the line buffer has one read and one write port.
// The last cell waits in stage 1 only while an earlier result has not been taken.
// Reset clears counters, best square and result valid, and loads the configuration defaults.
// The line buffer is not cleared; row 0 ignores what it reads.
`timescale 1ns / 1ps

module largest_empty_square_finder_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int SIZE_W    = $clog2(MAX_WIDTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [lesf_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [lesf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lesf_pkg::CHAR_W-1:0]       cell_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lesf_pkg::ROW_W-1:0]        best_row,
    output logic [COL_W-1:0]                  best_col,
    output logic [SIZE_W-1:0]                 best_size
);

    import lesf_pkg::*;

    logic [CHAR_W-1:0] empty_char_reg;
    logic [GW_W-1:0]   grid_width_reg;
    logic [ROW_W-1:0]  grid_height_reg;
    logic              restart;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_last;

    logic              s1_fire;
    logic              s1_valid;
    logic [CHAR_W-1:0] s1_cell;
    logic [COL_W-1:0]  s1_col;
    logic [ROW_W-1:0]  s1_row;
    cell_pos_t         s1_pos;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic [SIZE_W-1:0] rd_data;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [SIZE_W-1:0] wr_data;
    logic              res_load;
    logic [ROW_W-1:0]  res_row;
    logic [COL_W-1:0]  res_col;
    logic [SIZE_W-1:0] res_size;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ROW_W-1:0]  best_row_reg;
    logic [COL_W-1:0]  best_col_reg;
    logic [SIZE_W-1:0] best_size_reg;
    logic              out_busy;

    // Configuration registers; a write to any of the three registers restarts the grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_char_reg  <= EMPTY_CHAR_RST;
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_EMPTY_CHAR:  empty_char_reg  <= cfg_wdata[CHAR_W-1:0];
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[GW_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[ROW_W-1:0];
                default:         ;
            endcase
        end
    end

    assign restart = cfg_wr_en && ((cfg_addr == CFG_EMPTY_CHAR) ||
                                   (cfg_addr == CFG_GRID_WIDTH) ||
                                   (cfg_addr == CFG_GRID_HEIGHT));

    // Last column and row; zero width or height acts as one, width clamps to the buffer
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            col_last = '0;
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = COL_W'(grid_width_reg - GW_W'(1));
        end
        row_last = (grid_height_reg == '0) ? '0 : grid_height_reg - ROW_W'(1);
    end

    lesf_cell_seq #(
        .COL_W (COL_W)
    ) u_cell_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .col_last  (col_last),
        .row_last  (row_last),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cell_byte (cell_byte),
        .s1_fire   (s1_fire),
        .s1_valid  (s1_valid),
        .s1_cell   (s1_cell),
        .s1_col    (s1_col),
        .s1_row    (s1_row),
        .s1_pos    (s1_pos),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    lesf_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (SIZE_W)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lesf_square_track #(
        .COL_W  (COL_W),
        .SIZE_W (SIZE_W)
    ) u_square_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .empty_char (empty_char_reg),
        .s1_valid   (s1_valid),
        .s1_cell    (s1_cell),
        .s1_col     (s1_col),
        .s1_row     (s1_row),
        .s1_pos     (s1_pos),
        .up_mem     (rd_data),
        .out_busy   (out_busy),
        .s1_fire    (s1_fire),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res_load   (res_load),
        .res_row    (res_row),
        .res_col    (res_col),
        .res_size   (res_size)
    );

    // Result register
    assign out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            best_row_reg  <= res_row;
            best_col_reg  <= res_col;
            best_size_reg <= res_size;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_row  = best_row_reg;
    assign best_col  = best_col_reg;
    assign best_size = best_size_reg;

`ifndef ASSERT_OFF
    // A held last cell blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s1_pos.last_cell && out_busy) |-> !in_ready)
        else $error("request accepted while last cell is stalled");

    // Stage 1 column stays inside the configured row
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |-> (s1_col <= col_last))
        else $error("stage 1 column beyond last column");

    // An empty result reports the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((best_size != '0) || ((best_row == '0) && (best_col == '0))))
        else $error("zero-size result with nonzero corner");

    // A loaded result shows up on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid)
        else $error("result load lost");
`endif

endmodule

// ===== test/lesf_checker.sv =====
// Checker for the largest empty square finder: predicts each square result and compares it.
`timescale 1ns / 1ps

module lesf_checker
    import lesf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int SIZE_W    = $clog2(MAX_WIDTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [CHAR_W-1:0]     cell_byte,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [ROW_W-1:0]      best_row,
    input  logic [COL_W-1:0]      best_col,
    input  logic [SIZE_W-1:0]     best_size,
    output int                    mismatches,
    output int                    squares_pending,
    output int                    squares_checked,
    output int                    cells_scanned
);

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SIZE_W-1:0] size;
    } square_t;

    // Configuration copy
    logic [CHAR_W-1:0] empty_q;
    logic [GW_W-1:0]   width_q;
    logic [ROW_W-1:0]  height_q;

    // Scan state
    logic [SIZE_W-1:0] line_sizes [MAX_WIDTH];
    logic [SIZE_W-1:0] left_q;
    logic [SIZE_W-1:0] diag_q;
    logic [ROW_W-1:0]  row_q;
    logic [COL_W-1:0]  col_q;
    logic [SIZE_W-1:0] best_size_q;
    logic [ROW_W-1:0]  best_row_q;
    logic [COL_W-1:0]  best_col_q;

    square_t pending_squares[$];
    int      n_bad     = 0;
    int      n_checked = 0;
    int      n_cells   = 0;

    initial begin
        mismatches      = 0;
        squares_pending = 0;
        squares_checked = 0;
        cells_scanned   = 0;
    end

    // Start a new grid: counters, neighbors and best cleared
    task automatic clear_scan();
        left_q      = '0;
        diag_q      = '0;
        row_q       = '0;
        col_q       = '0;
        best_size_q = '0;
        best_row_q  = '0;
        best_col_q  = '0;
    endtask

    // One cell of the dynamic program; queues a square at the end of the grid
    task automatic scan_cell(input logic [CHAR_W-1:0] cb);
        int w;
        int h;
        int c;
        int r;
        int up;
        int lf;
        int dg;
        int sz;
        w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q));
        h = (height_q == 0) ? 1 : int'(height_q);
        c = (col_q >= w) ? w - 1 : int'(col_q);
        r = (row_q >= h) ? h - 1 : int'(row_q);
        up = (r > 0) ? int'(line_sizes[c]) : 0;
        lf = (c > 0) ? int'(left_q) : 0;
        dg = (r > 0 && c > 0) ? int'(diag_q) : 0;
        sz = 0;
        if (cb == empty_q) begin
            sz = (up < lf) ? up : lf;
            if (dg < sz)
                sz = dg;
            sz = sz + 1;
        end
        diag_q        = SIZE_W'(up);
        left_q        = SIZE_W'(sz);
        line_sizes[c] = SIZE_W'(sz);
        // strictly larger only: ties keep the earlier corner
        if (sz > best_size_q) begin
            best_size_q = SIZE_W'(sz);
            best_row_q  = ROW_W'(r + 1 - sz);
            best_col_q  = COL_W'(c + 1 - sz);
        end
        if (c + 1 >= w) begin
            col_q  = '0;
            left_q = '0;
            diag_q = '0;
            if (r + 1 >= h) begin
                pending_squares.push_back('{row: best_row_q, col: best_col_q,
                                            size: best_size_q});
                clear_scan();
            end else begin
                row_q = ROW_W'(r + 1);
            end
        end else begin
            col_q = COL_W'(c + 1);
            row_q = ROW_W'(r);
        end
    endtask

    // Watch the ports at each edge
    always @(posedge clk) begin
        square_t want;
        if (!rst_n) begin
            empty_q  = EMPTY_CHAR_RST;
            width_q  = GRID_WIDTH_RST;
            height_q = GRID_HEIGHT_RST;
            clear_scan();
            pending_squares.delete();
        end else begin
            // results first: they belong to grids finished earlier
            if (out_valid && out_ready) begin
                if (pending_squares.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: unexpected result row %0d col %0d size %0d",
                                 $time, best_row, best_col, best_size);
                end else begin
                    want = pending_squares.pop_front();
                    n_checked++;
                    if (best_row !== want.row || best_col !== want.col ||
                        best_size !== want.size) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("%0t: square mismatch: expected row %0d col %0d size %0d, got row %0d col %0d size %0d",
                                     $time, want.row, want.col, want.size,
                                     best_row, best_col, best_size);
                    end
                end
            end
            // any known register restarts the grid
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_EMPTY_CHAR:
                    begin
                        empty_q = cfg_wdata[CHAR_W-1:0];
                        clear_scan();
                    end
                    CFG_GRID_WIDTH:
                    begin
                        width_q = cfg_wdata[GW_W-1:0];
                        clear_scan();
                    end
                    CFG_GRID_HEIGHT:
                    begin
                        height_q = cfg_wdata[ROW_W-1:0];
                        clear_scan();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready) begin
                scan_cell(cell_byte);
                n_cells++;
            end
        end
        mismatches      <= n_bad;
        squares_pending <= pending_squares.size();
        squares_checked <= n_checked;
        cells_scanned   <= n_cells;
    end

endmodule

// ===== test/testbench.sv =====
// Testbench top for the largest empty square finder: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
    import lesf_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int SIZE_W       = $clog2(MAX_WIDTH + 1);
    localparam int RANDOM_CELLS = 580;
    localparam int LONG_HOLD    = 48;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    // Index past the register list: written, but has no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [CHAR_W-1:0]    DOT       = 8'h2E;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [CHAR_W-1:0]     cell_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ROW_W-1:0]      best_row;
    logic [COL_W-1:0]      best_col;
    logic [SIZE_W-1:0]     best_size;

    int mismatches;
    int squares_pending;
    int squares_checked;
    int cells_scanned;

    // Idling controls for the sender and the receiver, and the watchdog counter
    int tx_max_gap  = 7;
    int rx_max_gap  = 7;
    int rx_hold     = 0;
    int idle_cycles = 0;

    // Register contents as last written
    logic [CHAR_W-1:0] cfg_char   = EMPTY_CHAR_RST;
    logic [GW_W-1:0]   cfg_width  = GRID_WIDTH_RST;
    logic [ROW_W-1:0]  cfg_height = GRID_HEIGHT_RST;

    always #5 clk = ~clk;

    largest_empty_square_finder_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cell_byte(cell_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .best_row (best_row),
        .best_col (best_col),
        .best_size(best_size)
    );

    lesf_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cell_byte      (cell_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .best_row       (best_row),
        .best_col       (best_col),
        .best_size      (best_size),
        .mismatches     (mismatches),
        .squares_pending(squares_pending),
        .squares_checked(squares_checked),
        .cells_scanned  (cells_scanned)
    );

    // Watchdog: cycles with no accepted request, no taken result and no register write
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall per result, plus one long hold on demand
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            else
            begin
                gap = $urandom_range(rx_max_gap, 0);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Offer one cell request after a random gap and wait for it to be taken
    task automatic send_cell(input logic [CHAR_W-1:0] b);
        int gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cell_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Characters as cells: '.' is free when the empty char is '.'
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_cell(s[i]);
    endtask

    // Grid of the configured size; cells at or past (open_row, open_col) are free
    // with probability pct; cut > 0 stops after that many cells
    task automatic send_grid(input int pct, input int open_row, input int open_col,
                             input int cut);
        int ew;
        int eh;
        int n;
        ew = (cfg_width == 0) ? 1 :
             ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
        eh = (cfg_height == 0) ? 1 : int'(cfg_height);
        n  = 0;
        for (int r = 0; r < eh; r++)
        begin
            for (int c = 0; c < ew; c++)
            begin
                n++;
                if (cut > 0 && n > cut)
                    return;
                if (r >= open_row && c >= open_col && $urandom_range(99, 0) < pct)
                    send_cell(cfg_char);
                else
                    send_cell(cfg_char ^ CHAR_W'($urandom_range(255, 1)));
            end
        end
    endtask

    // Write the selected registers back to back; upper data bits of char and width writes carry junk
    task automatic program_grid(input logic [3:0] which, input logic [CHAR_W-1:0] ch,
                                input logic [GW_W-1:0] wd, input logic [ROW_W-1:0] ht);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        if (which[0])
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_EMPTY_CHAR;
            cfg_wdata <= {junk[CFG_DATA_W-1:CHAR_W], ch};
            cfg_char   = ch;
            @(posedge clk);
        end
        if (which[1])
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_GRID_WIDTH;
            cfg_wdata <= {junk[CFG_DATA_W-1:GW_W], wd};
            cfg_width  = wd;
            @(posedge clk);
        end
        if (which[2])
        begin
            cfg_wr_en  <= 1'b1;
            cfg_addr   <= CFG_GRID_HEIGHT;
            cfg_wdata  <= ht;
            cfg_height  = ht;
            @(posedge clk);
        end
        if (which[3])
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_SPARE;
            cfg_wdata <= junk;
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Sender idle until every expected square is in, then let the pipeline drain
    task automatic settle(input int tail);
        in_valid <= 1'b0;
        @(posedge clk);
        while (squares_pending != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                cell_base;
        int                pct;
        int                cut;
        int                grids;
        logic [3:0]        which;
        logic [CHAR_W-1:0] ch;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: one-cell grid, '.' is free
        send_cell(DOT);
        send_cell(8'h78);
        settle(DRAIN_CYCLES);

        // Spare index alone leaves the configuration as it was
        program_grid(4'b1000, DOT, GRID_WIDTH_RST, GRID_HEIGHT_RST);
        send_cell(DOT);
        settle(DRAIN_CYCLES);

        // Zero width and zero height fall back to one cell; byte 0x00 is free
        program_grid(4'b0111, 8'h00, 11'd0, 16'd0);
        send_cell(8'h00);
        send_cell(8'hFF);
        settle(DRAIN_CYCLES);

        // All-free 2x2 grid with 0xFF as the empty char
        program_grid(4'b0111, 8'hFF, 11'd2, 16'd2);
        send_grid(100, 0, 0, 0);
        settle(DRAIN_CYCLES);

        // Two equal 2x2 squares: the first in scan order wins
        program_grid(4'b0111, DOT, 11'd5, 16'd2);
        send_text("..x....x..");
        settle(DRAIN_CYCLES);

        // Grid abandoned part way, then a register write restarts the scan
        send_text("x..");
        settle(DRAIN_CYCLES);
        program_grid(4'b0010, DOT, 11'd2, 16'd2);
        send_text("....");
        settle(DRAIN_CYCLES);

        // Receiver holds off while one-cell grids keep coming: input must stall
        program_grid(4'b0111, DOT, 11'd1, 16'd1);
        tx_max_gap = 0;
        rx_hold    = LONG_HOLD;
        for (int i = 0; i < 12; i++)
            send_cell(($urandom_range(1, 0) != 0) ? DOT : 8'h23);
        settle(DRAIN_CYCLES);

        // Random grids, mostly small, with cuts and pauses between them
        cell_base = cells_scanned;
        while (cells_scanned - cell_base < RANDOM_CELLS)
        begin
            tx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 7;
            rx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 7;
            case ($urandom_range(5, 0))
                0:       ch = 8'h00;
                1:       ch = 8'hFF;
                default: ch = $urandom;
            endcase
            which = {1'($urandom_range(1, 0)), 3'($urandom_range(7, 1))};
            program_grid(which, ch, GW_W'($urandom_range(10, 0)),
                         ROW_W'($urandom_range(8, 0)));
            grids = $urandom_range(3, 1);
            for (int g = 0; g < grids; g++)
            begin
                case ($urandom_range(3, 0))
                    0:       pct = 15;
                    1:       pct = 60;
                    2:       pct = 90;
                    default: pct = 100;
                endcase
                cut = ($urandom_range(9, 0) == 0) ? $urandom_range(6, 1) : 0;
                send_grid(pct, 0, 0, cut);
                // a cut grid is left behind; the next register write restarts it
                if (cut > 0)
                    break;
                if ($urandom_range(4, 0) == 0)
                    settle(0);
            end
            settle(DRAIN_CYCLES);
        end

        // Extreme geometry with the sender at full rate
        tx_max_gap = 0;
        rx_max_gap = 7;
        // width above the maximum is clamped; the first row is left unfinished
        program_grid(4'b0111, DOT, 11'h7FF, 16'd1);
        send_grid(60, 0, 0, 48);
        settle(DRAIN_CYCLES);
        // tall single-column grid, free only in the last row
        program_grid(4'b0110, DOT, 11'd1, 16'd64);
        send_grid(100, 63, 0, 0);
        settle(DRAIN_CYCLES);
        // larger squares
        program_grid(4'b0111, 8'h20, 11'd14, 16'd14);
        send_grid(99, 0, 0, 0);

        settle(8);
        $display("run covered %0d cells and %0d squares: grids from 1x1 to 14x14 and 64 tall,",
                 cells_scanned, squares_checked);
        $display("with cut grids, a clamped width, idle gaps and a result hold that stalled input");
        if (mismatches == 0 && squares_pending == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("%0d mismatches, %0d squares never arrived", mismatches, squares_pending);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
